// ===== hdl/mrfp_pkg.sv =====
// Shared types, codes and constants of the modem response frame parser.
package mrfp_pkg;

    localparam int BUFFER_BYTES_DEF = 32;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_CMD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd1;

    localparam logic [7:0] MATCH_CMD_RST = 8'h4f;
    localparam logic [5:0] CAPACITY_RST  = 6'd32;

    // link bytes
    localparam logic [7:0] BYTE_STX      = 8'h02;
    localparam logic [7:0] BYTE_ACK      = 8'h06;
    localparam logic [7:0] BYTE_NAK      = 8'h15;
    localparam logic [7:0] BYTE_EVT_DONE = 8'h05;

    // command bytes
    localparam logic [7:0] CMD_FIX4_A = 8'h40;
    localparam logic [7:0] CMD_FIX4_B = 8'h46;
    localparam logic [7:0] CMD_FIX6_A = 8'h44;
    localparam logic [7:0] CMD_FIX6_B = 8'h48;
    localparam logic [7:0] CMD_FIX2   = 8'h4a;
    localparam logic [7:0] CMD_LENGTH = 8'h41;
    localparam logic [7:0] CMD_UPLOAD = 8'h42;
    localparam logic [7:0] CMD_SHORT1 = 8'h45;
    localparam logic [7:0] CMD_SHORT2 = 8'h47;
    localparam logic [7:0] CMD_EVENT  = 8'h4f;

    localparam logic [3:0] HC_FIX4     = 4'd4;
    localparam logic [3:0] HC_FIX6     = 4'd6;
    localparam logic [3:0] HC_FIX2     = 4'd2;
    localparam logic [3:0] HC_ONE      = 4'd1;
    localparam logic [3:0] HC_TWO      = 4'd2;
    localparam logic [3:0] HC_ZERO     = 4'd0;
    localparam logic [3:0] HC_MSG_LEN  = 4'd9;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TO_GENERAL = 3'd1;
    localparam logic [2:0] ST_TO_CMD     = 3'd2;
    localparam logic [2:0] ST_TO_UPHDR   = 3'd3;
    localparam logic [2:0] ST_TO_UPDATA  = 3'd4;
    localparam logic [2:0] ST_TO_UPSUM   = 3'd5;
    localparam logic [2:0] ST_TO_ACK     = 3'd6;

    typedef enum logic [3:0] {
        PH_HUNT, PH_CMD, PH_FIXED, PH_LEN, PH_DATA, PH_UPHDR,
        PH_UPDATA, PH_UPSUM, PH_SHORT, PH_EVENT, PH_MSG, PH_ACK
    } t_phase;

    typedef enum logic [1:0] {
        CS_IDLE, CS_TOUT, CS_RD, CS_LOAD
    } t_ctl_state;

    typedef enum logic [1:0] {
        HC_HOLD, HC_LOAD, HC_DEC, HC_INC
    } t_hc_op;

    typedef enum logic [1:0] {
        DR_HOLD, DR_LOAD_BYTE, DR_LOAD_UP, DR_DEC
    } t_dr_op;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       timed_out;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [2:0] status;
        logic [5:0] frame_length;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       keep;
        logic       set_cmd;
        logic       set_lhi;
        t_hc_op     hc_op;
        logic [3:0] hc_val;
        t_dr_op     dr_op;
        logic       clear;
        logic       tout_load;
        logic [2:0] tout_status;
        logic       ram_re;
        logic       out_load;
        logic       idx_inc;
    } t_dp_cmd;

    typedef struct packed {
        logic hc_le1;
        logic hc_eq2;
        logic hc_ge3;
        logic dr_le1;
        logic up_zero;
        logic cmd_match;
        logic out_free;
        logic emit_last;
    } t_dp_status;

endpackage

// ===== hdl/mrfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mrfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mrfp_ctrl.sv =====
// Parser controller: frame phase and emission sequencer state machines.
module mrfp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  mrfp_pkg::t_in_item    i_in_item,
    input  mrfp_pkg::t_dp_status  i_st,
    output logic                  o_in_ready,
    output mrfp_pkg::t_dp_cmd     o_cmd
);

    mrfp_pkg::t_phase     r_phase, n_phase;
    mrfp_pkg::t_ctl_state r_cs, n_cs;
    logic                 w_acc;
    logic [7:0]           w_b;

    assign w_acc = (r_cs == mrfp_pkg::CS_IDLE) && i_in_valid;
    assign w_b   = i_in_item.rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mrfp_pkg::PH_HUNT;
            r_cs    <= mrfp_pkg::CS_IDLE;
        end else begin
            r_phase <= n_phase;
            r_cs    <= n_cs;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_cs    = r_cs;
        unique case (r_cs)
            mrfp_pkg::CS_IDLE: begin
                if (w_acc && i_in_item.timed_out) begin
                    n_phase = mrfp_pkg::PH_HUNT;
                    n_cs    = mrfp_pkg::CS_TOUT;
                end else if (w_acc) begin
                    unique case (r_phase)
                        mrfp_pkg::PH_HUNT: begin
                            if (w_b == mrfp_pkg::BYTE_STX) n_phase = mrfp_pkg::PH_CMD;
                        end
                        mrfp_pkg::PH_CMD: begin
                            if (w_b != mrfp_pkg::BYTE_STX) begin
                                unique case (w_b)
                                    mrfp_pkg::CMD_FIX4_A, mrfp_pkg::CMD_FIX4_B,
                                    mrfp_pkg::CMD_FIX6_A, mrfp_pkg::CMD_FIX6_B,
                                    mrfp_pkg::CMD_FIX2:   n_phase = mrfp_pkg::PH_FIXED;
                                    mrfp_pkg::CMD_LENGTH: n_phase = mrfp_pkg::PH_LEN;
                                    mrfp_pkg::CMD_UPLOAD: n_phase = mrfp_pkg::PH_UPHDR;
                                    mrfp_pkg::CMD_SHORT1,
                                    mrfp_pkg::CMD_SHORT2: n_phase = mrfp_pkg::PH_SHORT;
                                    mrfp_pkg::CMD_EVENT:  n_phase = mrfp_pkg::PH_EVENT;
                                    default:              n_phase = mrfp_pkg::PH_ACK;
                                endcase
                            end
                        end
                        mrfp_pkg::PH_FIXED: begin
                            if (i_st.hc_le1) n_phase = mrfp_pkg::PH_ACK;
                        end
                        mrfp_pkg::PH_LEN: begin
                            n_phase = (w_b == 8'd0) ? mrfp_pkg::PH_ACK : mrfp_pkg::PH_DATA;
                        end
                        mrfp_pkg::PH_DATA: begin
                            if (i_st.dr_le1) n_phase = mrfp_pkg::PH_ACK;
                        end
                        mrfp_pkg::PH_UPHDR: begin
                            if (i_st.hc_ge3) begin
                                n_phase = i_st.up_zero ? mrfp_pkg::PH_UPSUM
                                                       : mrfp_pkg::PH_UPDATA;
                            end
                        end
                        mrfp_pkg::PH_UPDATA: begin
                            if (i_st.dr_le1) n_phase = mrfp_pkg::PH_UPSUM;
                        end
                        mrfp_pkg::PH_UPSUM: begin
                            if (i_st.hc_le1) n_phase = mrfp_pkg::PH_ACK;
                        end
                        mrfp_pkg::PH_SHORT, mrfp_pkg::PH_MSG: begin
                            if (i_st.hc_le1) begin
                                n_phase = mrfp_pkg::PH_HUNT;
                                if (i_st.cmd_match) n_cs = mrfp_pkg::CS_RD;
                            end
                        end
                        mrfp_pkg::PH_EVENT: begin
                            if (w_b == mrfp_pkg::BYTE_EVT_DONE) begin
                                n_phase = mrfp_pkg::PH_HUNT;
                                n_cs    = mrfp_pkg::CS_RD;
                            end else begin
                                n_phase = mrfp_pkg::PH_MSG;
                            end
                        end
                        mrfp_pkg::PH_ACK: begin
                            if (w_b == mrfp_pkg::BYTE_ACK || w_b == mrfp_pkg::BYTE_NAK) begin
                                n_phase = mrfp_pkg::PH_HUNT;
                                if (i_st.cmd_match) n_cs = mrfp_pkg::CS_RD;
                            end else if (w_b == mrfp_pkg::BYTE_STX) begin
                                n_phase = mrfp_pkg::PH_CMD;
                            end
                        end
                        default: n_phase = mrfp_pkg::PH_HUNT;
                    endcase
                end
            end
            mrfp_pkg::CS_TOUT: begin
                if (i_st.out_free) n_cs = mrfp_pkg::CS_IDLE;
            end
            mrfp_pkg::CS_RD: n_cs = mrfp_pkg::CS_LOAD;
            mrfp_pkg::CS_LOAD: begin
                if (i_st.out_free) begin
                    n_cs = i_st.emit_last ? mrfp_pkg::CS_IDLE : mrfp_pkg::CS_RD;
                end
            end
            default: n_cs = mrfp_pkg::CS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_cmd.hc_op = mrfp_pkg::HC_HOLD;
        o_cmd.dr_op = mrfp_pkg::DR_HOLD;
        o_in_ready  = (r_cs == mrfp_pkg::CS_IDLE);
        unique case (r_cs)
            mrfp_pkg::CS_IDLE: begin
                if (w_acc && i_in_item.timed_out) begin
                    o_cmd.clear     = 1'b1;
                    o_cmd.tout_load = 1'b1;
                    unique case (r_phase)
                        mrfp_pkg::PH_CMD:    o_cmd.tout_status = mrfp_pkg::ST_TO_CMD;
                        mrfp_pkg::PH_UPHDR:  o_cmd.tout_status = mrfp_pkg::ST_TO_UPHDR;
                        mrfp_pkg::PH_UPDATA: o_cmd.tout_status = mrfp_pkg::ST_TO_UPDATA;
                        mrfp_pkg::PH_UPSUM:  o_cmd.tout_status = mrfp_pkg::ST_TO_UPSUM;
                        mrfp_pkg::PH_ACK:    o_cmd.tout_status = mrfp_pkg::ST_TO_ACK;
                        default:             o_cmd.tout_status = mrfp_pkg::ST_TO_GENERAL;
                    endcase
                end else if (w_acc) begin
                    unique case (r_phase)
                        mrfp_pkg::PH_HUNT: ;
                        mrfp_pkg::PH_CMD: begin
                            o_cmd.set_cmd = 1'b1;
                            o_cmd.keep    = 1'b1;
                            unique case (w_b)
                                mrfp_pkg::CMD_FIX4_A, mrfp_pkg::CMD_FIX4_B: begin
                                    o_cmd.hc_op  = mrfp_pkg::HC_LOAD;
                                    o_cmd.hc_val = mrfp_pkg::HC_FIX4;
                                end
                                mrfp_pkg::CMD_FIX6_A, mrfp_pkg::CMD_FIX6_B: begin
                                    o_cmd.hc_op  = mrfp_pkg::HC_LOAD;
                                    o_cmd.hc_val = mrfp_pkg::HC_FIX6;
                                end
                                mrfp_pkg::CMD_FIX2: begin
                                    o_cmd.hc_op  = mrfp_pkg::HC_LOAD;
                                    o_cmd.hc_val = mrfp_pkg::HC_FIX2;
                                end
                                mrfp_pkg::CMD_UPLOAD: begin
                                    o_cmd.hc_op  = mrfp_pkg::HC_LOAD;
                                    o_cmd.hc_val = mrfp_pkg::HC_ZERO;
                                end
                                mrfp_pkg::CMD_SHORT1: begin
                                    o_cmd.hc_op  = mrfp_pkg::HC_LOAD;
                                    o_cmd.hc_val = mrfp_pkg::HC_ONE;
                                end
                                mrfp_pkg::CMD_SHORT2: begin
                                    o_cmd.hc_op  = mrfp_pkg::HC_LOAD;
                                    o_cmd.hc_val = mrfp_pkg::HC_TWO;
                                end
                                default: ;
                            endcase
                        end
                        mrfp_pkg::PH_FIXED, mrfp_pkg::PH_UPSUM,
                        mrfp_pkg::PH_SHORT, mrfp_pkg::PH_MSG: begin
                            o_cmd.keep  = 1'b1;
                            o_cmd.hc_op = mrfp_pkg::HC_DEC;
                            if ((r_phase == mrfp_pkg::PH_SHORT || r_phase == mrfp_pkg::PH_MSG)
                                && i_st.hc_le1 && !i_st.cmd_match) begin
                                o_cmd.clear = 1'b1;
                            end
                        end
                        mrfp_pkg::PH_LEN: o_cmd.dr_op = mrfp_pkg::DR_LOAD_BYTE;
                        mrfp_pkg::PH_DATA: begin
                            o_cmd.keep  = 1'b1;
                            o_cmd.dr_op = mrfp_pkg::DR_DEC;
                        end
                        mrfp_pkg::PH_UPHDR: begin
                            o_cmd.keep    = 1'b1;
                            o_cmd.set_lhi = i_st.hc_eq2;
                            if (i_st.hc_ge3) begin
                                o_cmd.dr_op  = mrfp_pkg::DR_LOAD_UP;
                                o_cmd.hc_op  = mrfp_pkg::HC_LOAD;
                                o_cmd.hc_val = mrfp_pkg::HC_TWO;
                            end else begin
                                o_cmd.hc_op = mrfp_pkg::HC_INC;
                            end
                        end
                        mrfp_pkg::PH_UPDATA: begin
                            o_cmd.keep  = 1'b1;
                            o_cmd.dr_op = mrfp_pkg::DR_DEC;
                            if (i_st.dr_le1) begin
                                o_cmd.hc_op  = mrfp_pkg::HC_LOAD;
                                o_cmd.hc_val = mrfp_pkg::HC_TWO;
                            end
                        end
                        mrfp_pkg::PH_EVENT: begin
                            o_cmd.keep = 1'b1;
                            if (w_b != mrfp_pkg::BYTE_EVT_DONE) begin
                                o_cmd.hc_op  = mrfp_pkg::HC_LOAD;
                                o_cmd.hc_val = mrfp_pkg::HC_MSG_LEN;
                            end
                        end
                        mrfp_pkg::PH_ACK: begin
                            o_cmd.keep = 1'b1;
                            if ((w_b == mrfp_pkg::BYTE_ACK || w_b == mrfp_pkg::BYTE_NAK)
                                && !i_st.cmd_match) begin
                                o_cmd.clear = 1'b1;
                            end
                        end
                        default: o_cmd.clear = 1'b1;
                    endcase
                end
            end
            mrfp_pkg::CS_TOUT: ;
            mrfp_pkg::CS_RD: o_cmd.ram_re = 1'b1;
            mrfp_pkg::CS_LOAD: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.clear    = i_st.emit_last;
                    o_cmd.idx_inc  = !i_st.emit_last;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/mrfp_dp.sv =====
// Parser datapath: config registers, counters, frame store and output register.
module mrfp_dp #(
    parameter int BUFFER_BYTES = mrfp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mrfp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [7:0]                         i_cfg_data,
    input  mrfp_pkg::t_in_item                 i_in_item,
    input  mrfp_pkg::t_dp_cmd                  i_cmd,
    output mrfp_pkg::t_dp_status               o_st,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output mrfp_pkg::t_out_item                o_out_item
);

    localparam int AW   = $clog2(BUFFER_BYTES);
    localparam int CW   = $clog2(BUFFER_BYTES + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    logic [7:0]          r_match, r_cur_cmd, r_lhi;
    logic [5:0]          r_capacity;
    logic [CW-1:0]       r_count;
    logic [3:0]          r_hc;
    logic [15:0]         r_dr;
    logic [AW-1:0]       r_rd_idx;
    logic [2:0]          r_tout_st;
    logic                r_tout_pend;
    logic                r_out_valid;
    mrfp_pkg::t_out_item r_out;

    logic [7:0]          w_b;
    logic [CMPW-1:0]     w_cap, w_eff_cap;
    logic                w_store;
    logic [7:0]          w_rdata;

    assign w_b       = i_in_item.rx_byte;
    assign w_cap     = CMPW'(r_capacity);
    assign w_eff_cap = (w_cap > CMPW'(BUFFER_BYTES)) ? CMPW'(BUFFER_BYTES) : w_cap;
    assign w_store   = i_cmd.keep && (CMPW'(r_count) < w_eff_cap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= mrfp_pkg::MATCH_CMD_RST;
            r_capacity <= mrfp_pkg::CAPACITY_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == mrfp_pkg::REG_MATCH_CMD) r_match <= i_cfg_data;
            if (i_cfg_index == mrfp_pkg::REG_CAPACITY)  r_capacity <= i_cfg_data[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_cmd <= '0;
            r_lhi     <= '0;
            r_count   <= '0;
            r_hc      <= '0;
            r_dr      <= '0;
            r_rd_idx  <= '0;
        end else begin
            if (i_cmd.set_cmd) r_cur_cmd <= w_b;
            if (i_cmd.clear) begin
                r_lhi    <= '0;
                r_count  <= '0;
                r_hc     <= '0;
                r_dr     <= '0;
                r_rd_idx <= '0;
            end else begin
                if (w_store) r_count <= r_count + CW'(1);
                if (i_cmd.set_lhi) r_lhi <= w_b;
                if (i_cmd.idx_inc) r_rd_idx <= r_rd_idx + AW'(1);
                unique case (i_cmd.hc_op)
                    mrfp_pkg::HC_HOLD: ;
                    mrfp_pkg::HC_LOAD: r_hc <= i_cmd.hc_val;
                    mrfp_pkg::HC_DEC:  if (r_hc != 4'd0) r_hc <= r_hc - 4'd1;
                    mrfp_pkg::HC_INC:  r_hc <= r_hc + 4'd1;
                    default: ;
                endcase
                unique case (i_cmd.dr_op)
                    mrfp_pkg::DR_HOLD: ;
                    mrfp_pkg::DR_LOAD_BYTE: r_dr <= {8'd0, w_b};
                    mrfp_pkg::DR_LOAD_UP:   r_dr <= {r_lhi, w_b};
                    mrfp_pkg::DR_DEC:       if (r_dr != 16'd0) r_dr <= r_dr - 16'd1;
                    default: ;
                endcase
            end
        end
    end

    mrfp_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_BYTES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_store),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(w_b),
        .i_re   (i_cmd.ram_re),
        .i_raddr(r_rd_idx),
        .o_rdata(w_rdata)
    );

    always_comb begin
        o_st.hc_le1    = (r_hc <= 4'd1);
        o_st.hc_eq2    = (r_hc == 4'd2);
        o_st.hc_ge3    = (r_hc >= 4'd3);
        o_st.dr_le1    = (r_dr <= 16'd1);
        o_st.up_zero   = ({r_lhi, w_b} == 16'd0);
        o_st.cmd_match = (r_cur_cmd == r_match);
        o_st.out_free  = !r_out_valid || i_out_ready;
        o_st.emit_last = (r_count == '0) || ((CW'(r_rd_idx) + CW'(1)) == r_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tout_load) r_tout_st <= i_cmd.tout_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load || (r_tout_pend && o_st.out_free)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // a timeout report waits in r_tout_pend until the output register is free, then is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tout_pend <= 1'b0;
        end else if (i_cmd.tout_load) begin
            r_tout_pend <= 1'b1;
        end else if (o_st.out_free) begin
            r_tout_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.frame_byte   <= (r_count == '0) ? 8'd0 : w_rdata;
            r_out.status       <= mrfp_pkg::ST_OK;
            r_out.frame_length <= 6'(r_count);
            r_out.last         <= o_st.emit_last;
        end else if (r_tout_pend && o_st.out_free) begin
            r_out.frame_byte   <= 8'd0;
            r_out.status       <= r_tout_st;
            r_out.frame_length <= 6'd0;
            r_out.last         <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== hdl/modem_response_frame_parser_core.sv =====
// Top level of the modem response frame parser.
// Takes one link byte or timeout marker per item and is ready again in the next cycle for
// any byte that completes no frame. A timeout report passes through a pending register into
// the output register once the sink has freed that register, and the block is ready again
// from that same cycle. A completed frame (one whose command matches the match register, or
// an event frame closed by its done byte) of N stored bytes is then streamed from the frame
// store, each byte by one store read and then one output register load (an empty frame still
// gives one item), and input is held off until the final byte is loaded. Configuration writes are taken in any cycle.
module modem_response_frame_parser_core #(
    parameter int BUFFER_BYTES = mrfp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  mrfp_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output mrfp_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mrfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    mrfp_pkg::t_dp_cmd    w_cmd;
    mrfp_pkg::t_dp_status w_st;

    assign o_cfg_ready = 1'b1;

    mrfp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_item (i_in_item),
        .i_st      (w_st),
        .o_in_ready(o_in_ready),
        .o_cmd     (w_cmd)
    );

    mrfp_dp #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_item  (i_in_item),
        .i_cmd      (w_cmd),
        .o_st       (w_st),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item)
    );

endmodule

// ===== hdl/mrfp_chk.sv =====
// Port-level checker for the modem response frame parser, bound to the top level.
module mrfp_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input mrfp_pkg::t_in_item             i_in_item,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input mrfp_pkg::t_out_item            o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    a_tout_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != mrfp_pkg::ST_OK) |->
        o_out_item.last && (o_out_item.frame_length == 6'd0) &&
        (o_out_item.frame_byte == 8'd0))
        else $error("timeout report malformed");

    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == mrfp_pkg::ST_OK) && !o_out_item.last |->
        (o_out_item.frame_length != 6'd0))
        else $error("non-final frame item with zero length");

    a_tout_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.timed_out |=> !o_in_ready)
        else $error("item taken while timeout report pending");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind modem_response_frame_parser_core mrfp_chk u_chk (.*);
